// ===== rtl/cfsm_pkg.sv =====
`timescale 1ns / 1ps

package cfsm_pkg;

  localparam int PatternMaxDef = 8;
  localparam int ByteW         = 8;
  localparam int PatBytesW     = 64;
  localparam int PatLenW       = 4;
  localparam int CfgIdxW       = 1;
  localparam int CfgDataW      = 64;
  localparam int PatSlots      = PatBytesW / ByteW;
  localparam int SlotIdxW      = $clog2(PatSlots);

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternBytes  = 1'b0,
    CfgPatternLength = 1'b1
  } cfg_reg_e;

  // Lower-case fold for single-byte CP1251.
  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'hC0 && b <= 8'hDF)) begin
      r = b + 8'h20;
    end else if (b == 8'hA8) begin
      r = 8'hB8;
    end
    return r;
  endfunction

endpackage

// ===== rtl/cfsm_cell.sv =====
`timescale 1ns / 1ps

// One window position: hold a folded text byte, pass it on to the next cell,
// and check it against the pattern character lined up with it.
module cfsm_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        shift_i,
  input  logic                        clear_i,
  input  logic [cfsm_pkg::ByteW-1:0]  byte_i,
  input  logic [cfsm_pkg::ByteW-1:0]  pat_char_i,
  input  logic                        in_use_i,
  output logic [cfsm_pkg::ByteW-1:0]  byte_o,
  output logic                        ok_o
);

  logic [cfsm_pkg::ByteW-1:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (clear_i) begin
      byte_d = '0;
    end else if (shift_i) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;
  // A cell beyond the pattern length does not take part.
  assign ok_o   = !in_use_i || (byte_q == pat_char_i);

endmodule

// ===== rtl/case_folding_substring_matcher.sv =====
`timescale 1ns / 1ps
// Case-folding substring matcher.
// Result: the outcome of an accepted input transaction is registered and shows on the master side in the next cycle.
// Throughput: one byte per cycle while m_axis_tready holds; the fold, the compare across
//   the cell chain and the window shift all settle in the single cycle in which the byte is accepted.
// Reset: asynchronous, active low; clears the window, counts, output register, pattern
//   bytes to zero and pattern length to one.

module case_folding_substring_matcher #(
  parameter int PatternMax = cfsm_pkg::PatternMaxDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [cfsm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cfsm_pkg::CfgDataW-1:0]  cfg_data_i,
  // Text stream in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  logic                           s_axis_tlast,   // text_last
  // Result stream out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [0] match_end, [1] found, rest zero
  output logic                           m_axis_tlast    // text_end
);

  localparam int ByteW  = cfsm_pkg::ByteW;
  localparam int LenW   = cfsm_pkg::PatLenW;
  localparam int SlotW  = cfsm_pkg::SlotIdxW;
  localparam int NCells = (PatternMax > 1) ? PatternMax - 1 : 1;
  localparam int CntW   = (PatternMax > 1) ? $clog2(PatternMax) : 1;

  // Configuration: keep the pattern already folded, and the raw length.
  logic [cfsm_pkg::PatSlots-1:0][ByteW-1:0] pat_q, pat_d;
  logic [LenW-1:0]                          len_q, len_d;

  always_comb begin
    pat_d = pat_q;
    len_d = len_q;
    if (cfg_we_i) begin
      case (cfsm_pkg::cfg_reg_e'(cfg_index_i))
        cfsm_pkg::CfgPatternBytes: begin
          for (int i = 0; i < cfsm_pkg::PatSlots; i++) begin
            pat_d[i] = cfsm_pkg::fold_byte(cfg_data_i[i*ByteW +: ByteW]);
          end
        end
        cfsm_pkg::CfgPatternLength: begin
          len_d = cfg_data_i[LenW-1:0];
        end
        default: begin
          len_d = len_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      len_q <= LenW'(1);
    end else begin
      pat_q <= pat_d;
      len_q <= len_d;
    end
  end

  // Clamp the length into 1..PatternMax, then work with length minus one.
  logic [LenW-1:0] len_c;
  logic [LenW-1:0] len_m1;

  always_comb begin
    len_c = len_q;
    if (len_q == '0) begin
      len_c = LenW'(1);
    end else if (len_q > LenW'(PatternMax)) begin
      len_c = LenW'(PatternMax);
    end
  end
  assign len_m1 = len_c - LenW'(1);

  // Handshake: the output register frees whenever its result is taken.
  logic accept;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic [ByteW-1:0] cur;
  assign cur = cfsm_pkg::fold_byte(s_axis_tdata);

  // Window cell chain: cell 0 holds the most recent earlier byte.
  logic [NCells-1:0][ByteW-1:0] cell_byte;
  logic [NCells-1:0]            cell_ok;
  logic                         all_cells_ok;

  generate
    if (PatternMax > 1) begin : g_chain
      for (genvar k = 0; k < PatternMax - 1; k++) begin : g_cell
        logic [ByteW-1:0] chain_in;
        logic [LenW-1:0]  pidx;

        if (k == 0) begin : g_head
          assign chain_in = cur;
        end else begin : g_link
          assign chain_in = cell_byte[k-1];
        end

        // Cell k lines up with pattern character len-2-k.
        assign pidx = len_m1 - LenW'(k + 1);

        cfsm_cell u_cell (
          .clk_i      (clk_i),
          .rst_ni     (rst_ni),
          .shift_i    (accept),
          .clear_i    (accept && s_axis_tlast),
          .byte_i     (chain_in),
          .pat_char_i (pat_q[pidx[SlotW-1:0]]),
          .in_use_i   (len_m1 > LenW'(k)),
          .byte_o     (cell_byte[k]),
          .ok_o       (cell_ok[k])
        );
      end
      assign all_cells_ok = &cell_ok;
    end else begin : g_nochain
      assign cell_byte    = '0;
      assign cell_ok      = '1;
      assign all_cells_ok = &cell_ok && (cell_byte == '0);
    end
  endgenerate

  // Bytes seen in this text, saturating at PatternMax-1.
  logic [CntW-1:0] seen_q, seen_d;
  logic            found_q, found_d;
  logic            match;

  assign match = (LenW'(seen_q) >= len_m1)
              && (pat_q[len_m1[SlotW-1:0]] == cur)
              && all_cells_ok;

  always_comb begin
    seen_d  = seen_q;
    found_d = found_q;
    if (accept) begin
      if (s_axis_tlast) begin
        seen_d  = '0;
        found_d = 1'b0;
      end else begin
        found_d = found_q || match;
        if (32'(seen_q) < PatternMax - 1) begin
          seen_d = seen_q + CntW'(1);
        end
      end
    end
  end

  // Output register.
  logic out_match_q, out_match_d;
  logic out_found_q, out_found_d;
  logic out_last_q,  out_last_d;
  logic out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    out_match_d = out_match_q;
    out_found_d = out_found_q;
    out_last_d  = out_last_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_match_d = match;
      out_found_d = found_q || match;
      out_last_d  = s_axis_tlast;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_match_q <= 1'b0;
      out_found_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      out_match_q <= out_match_d;
      out_found_q <= out_found_d;
      out_last_q  <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_found_q, out_match_q};
  assign m_axis_tlast  = out_last_q;

endmodule
